/* rtl/mkrs_pkg.sv */
// Shared constants, types and the sort rank function of the record sorter.
package mkrs_pkg;

    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = 32;
    localparam int SW = 31;
    localparam int KW = PW + SW;
    localparam int RW = PW + 1 + SW + AW;
    localparam int IW = 7;

    typedef logic [KW-1:0] key_t;
    typedef logic [RW-1:0] rank_t;

    // Smaller rank goes first: primary descending, odd secondary first,
    // secondary ascending, slot (arrival order) ascending.
    function automatic rank_t rank_of(input key_t key, input logic [AW-1:0] slot);
        logic [PW-1:0] pk;
        logic [SW-1:0] sk;
        pk = key[KW-1:SW];
        sk = key[SW-1:0];
        return {~{~pk[PW-1], pk[PW-2:0]}, ~sk[0], sk, slot};
    endfunction

endpackage

/* rtl/mkrs_ram.sv */
// Record key memory: one write port, one registered read port.
module mkrs_ram
    import mkrs_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  key_t          wdata,
    input  logic [AW-1:0] raddr,
    output key_t          rdata
);

    key_t mem [CAPACITY];

    // Write record keys
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/multi_key_record_sorter.sv */
// Loading: one record beat per cycle, no stall while loading.
// Sorting: each result needs one scan of the n stored records through the
// single memory read port.
// Inputs stall from the final record until the last result beat is taken.
// Reset (rst_n low, asynchronous) empties the set and clears the drop flag.
module multi_key_record_sorter
    import mkrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_valid,
    output logic                 rec_stall,
    input  logic signed [PW-1:0] primary_key,
    input  logic [SW-1:0]        secondary_key,
    input  logic                 final_record,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [IW-1:0]        record_index,
    output logic                 end_of_run,
    output logic                 overflow
);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [CW-1:0] raddr_reg, raddr_next;
    logic          rvld_reg, rvld_next;
    logic [AW-1:0] rslot_reg, rslot_next;
    rank_t         best_reg, best_next;
    logic          found_reg, found_next;
    rank_t         last_reg, last_next;
    logic          have_last_reg, have_last_next;
    logic [CW-1:0] emitted_reg, emitted_next;

    logic          rec_acc;
    logic          res_acc;
    logic          store;
    key_t          rdata;
    rank_t         cand;
    logic          issue;
    logic          is_end;

    assign rec_acc = rec_valid && !rec_stall;
    assign res_acc = res_valid && !res_stall;
    assign store   = rec_acc && (count_reg != CW'(CAPACITY));
    assign issue   = (state_reg == ST_SCAN) && (raddr_reg != count_reg);
    assign cand    = rank_of(rdata, rslot_reg);
    assign is_end  = (emitted_reg + CW'(1)) == count_reg;

    mkrs_ram u_ram (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[AW-1:0]),
        .wdata ({primary_key, secondary_key}),
        .raddr (raddr_reg[AW-1:0]),
        .rdata (rdata)
    );

    // Load, scan for next rank above the last emitted, present result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        raddr_next     = raddr_reg;
        rvld_next      = 1'b0;
        rslot_next     = raddr_reg[AW-1:0];
        best_next      = best_reg;
        found_next     = found_reg;
        last_next      = last_reg;
        have_last_next = have_last_reg;
        emitted_next   = emitted_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (rec_acc)
                begin
                    if (store)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (final_record)
                    begin
                        state_next     = ST_SCAN;
                        raddr_next     = '0;
                        found_next     = 1'b0;
                        have_last_next = 1'b0;
                        emitted_next   = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    raddr_next = raddr_reg + CW'(1);
                    rvld_next  = 1'b1;
                end
                if (rvld_reg && (!have_last_reg || cand > last_reg)
                    && (!found_reg || cand < best_reg))
                begin
                    best_next  = cand;
                    found_next = 1'b1;
                end
                if (!issue && !rvld_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_acc)
                begin
                    last_next      = best_reg;
                    have_last_next = 1'b1;
                    emitted_next   = emitted_reg + CW'(1);
                    found_next     = 1'b0;
                    raddr_next     = '0;
                    if (is_end)
                    begin
                        state_next   = ST_LOAD;
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            raddr_reg     <= '0;
            rvld_reg      <= 1'b0;
            found_reg     <= 1'b0;
            have_last_reg <= 1'b0;
            emitted_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            raddr_reg     <= raddr_next;
            rvld_reg      <= rvld_next;
            found_reg     <= found_next;
            have_last_reg <= have_last_next;
            emitted_reg   <= emitted_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rslot_reg <= rslot_next;
        best_reg  <= best_next;
        last_reg  <= last_next;
    end

    // Drive ports
    assign rec_stall    = (state_reg != ST_LOAD);
    assign res_valid    = (state_reg == ST_OUT);
    assign record_index = IW'({1'b0, best_reg[AW-1:0]}) + IW'(1);
    assign end_of_run   = is_end;
    assign overflow     = dropped_reg;

endmodule

/* verif/tb_multi_key_record_sorter.sv */
// Testbench for the multi-key record sorter: directed and random sets against a sort predictor.
module tb_multi_key_record_sorter
    import mkrs_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IW-1:0] idx;
        logic          last;
        logic          ovf;
    } sorted_beat_t;

    typedef struct {
        logic signed [PW-1:0] pk;
        logic [SW-1:0]        sk;
        logic [IW-1:0]        idx;
    } held_rec_t;

    logic                 clk;
    logic                 rst_n;
    logic                 rec_valid;
    logic                 rec_stall;
    logic signed [PW-1:0] primary_key;
    logic [SW-1:0]        secondary_key;
    logic                 final_record;
    logic                 res_valid;
    logic                 res_stall;
    logic [IW-1:0]        record_index;
    logic                 end_of_run;
    logic                 overflow;

    sorted_beat_t sorted_q[$];
    held_rec_t    held_set[$];
    logic         set_dropped;
    int           errors;
    int           cycles;
    int           records_sent;
    int           sets_sent;
    int           beats_checked;
    int           stall_left;
    bit           hold_stall_off;

    multi_key_record_sorter dut (
        .clk(clk), .rst_n(rst_n),
        .rec_valid(rec_valid), .rec_stall(rec_stall),
        .primary_key(primary_key), .secondary_key(secondary_key),
        .final_record(final_record),
        .res_valid(res_valid), .res_stall(res_stall),
        .record_index(record_index), .end_of_run(end_of_run), .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // true if record a sorts ahead of record b
    function automatic bit sorts_ahead(held_rec_t a, held_rec_t b);
        if (a.pk != b.pk) return a.pk > b.pk;
        if (a.sk[0] != b.sk[0]) return a.sk[0];
        if (a.sk != b.sk) return a.sk < b.sk;
        return a.idx < b.idx;
    endfunction

    // store one record in the predictor; on a final record queue the sorted indices
    function automatic void predict_record(logic signed [PW-1:0] pk, logic [SW-1:0] sk,
                                           logic fin);
        held_rec_t    r;
        held_rec_t    ord[$];
        sorted_beat_t b;
        int           j;
        if (held_set.size() < CAPACITY)
        begin
            r.pk = pk;
            r.sk = sk;
            r.idx = IW'(held_set.size() + 1);
            held_set.insert(held_set.size(), r);
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (!fin) return;
        foreach (held_set[i])
        begin
            j = 0;
            while (j < ord.size() && !sorts_ahead(held_set[i], ord[j])) j++;
            ord.insert(j, held_set[i]);
        end
        foreach (ord[i])
        begin
            b.idx  = ord[i].idx;
            b.last = (i == ord.size() - 1);
            b.ovf  = set_dropped;
            sorted_q.insert(sorted_q.size(), b);
        end
        held_set.delete();
        set_dropped = 1'b0;
    endfunction

    // send one record beat after a random gap; valid stays up until the next gap
    task automatic send_record(logic signed [PW-1:0] pk, logic [SW-1:0] sk, logic fin);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            rec_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rec_valid <= 1'b1;
        primary_key <= pk;
        secondary_key <= sk;
        final_record <= fin;
        @(posedge clk);
        while (rec_stall) @(posedge clk);
        predict_record(pk, sk, fin);
        records_sent++;
        if (fin) sets_sent++;
    endtask

    // drop valid and hold until every expected beat has come
    task automatic drain_results();
        rec_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [SW-1:0] rand_secondary();
        case ($urandom_range(0, 3))
            0: return SW'($urandom_range(0, 7));
            1: return {1'b1, 30'($urandom)};
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic signed [PW-1:0] rand_primary();
        case ($urandom_range(0, 3))
            0: return PW'($signed($urandom_range(0, 6)) - 3);
            1: return {1'b1, 31'($urandom_range(0, 3))};
            default: return PW'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        send_record(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_record(32'sh8000_0000, 31'd0, 1'b0);
        send_record(32'sd0, 31'd1, 1'b0);
        send_record(32'sd0, 31'd2, 1'b0);
        send_record(32'sd0, 31'd1, 1'b0);
        send_record(-32'sd1, 31'h7FFF_FFFE, 1'b0);
        send_record(32'sh7FFF_FFFF, 31'd0, 1'b1);
        // single-record set
        send_record(32'sd5, 31'd3, 1'b1);
        drain_results();
    endtask

    task automatic test_ties();
        for (int i = 0; i < 6; i++)
            send_record(32'sd7, SW'(i % 2 ? 9 : 4), i == 5);
        drain_results();
    endtask

    // fill past capacity so records drop and the set reports overflow
    task automatic test_overflow();
        for (int i = 0; i < CAPACITY + 3; i++)
            send_record(rand_primary(), rand_secondary(), i == CAPACITY + 2);
        drain_results();
        // exactly full set, no drop
        for (int i = 0; i < CAPACITY; i++)
            send_record(rand_primary(), rand_secondary(), i == CAPACITY - 1);
        drain_results();
    endtask

    task automatic test_random_sets();
        int len;
        while (records_sent < 320)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_record(rand_primary(), rand_secondary(), i == len - 1);
            if ($urandom_range(0, 4) == 0) drain_results();
        end
        drain_results();
    endtask

    // result side: check each taken beat, then draw a random stall before the next, unless hold_stall_off is set
    always @(posedge clk)
    begin
        sorted_beat_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                beats_checked++;
                if (sorted_q.size() == 0)
                begin
                    $display("%0t unexpected result idx=%0d last=%0b ovf=%0b", $time,
                             record_index, end_of_run, overflow);
                    errors++;
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (want != {record_index, end_of_run, overflow})
                    begin
                        $display("%0t mismatch expected idx=%0d last=%0b ovf=%0b",
                                 $time, want.idx, want.last, want.ovf);
                        $display("%0t          got idx=%0d last=%0b ovf=%0b",
                                 $time, record_index, end_of_run, overflow);
                        errors++;
                    end
                end
                stall_left = $urandom_range(0, 3);
            end
            if (hold_stall_off)
            begin
                stall_left = 0;
                res_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 600000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        rec_valid = 1'b0;
        res_stall = 1'b0;
        primary_key = '0;
        secondary_key = '0;
        final_record = 1'b0;
        set_dropped = 1'b0;
        errors = 0;
        cycles = 0;
        records_sent = 0;
        sets_sent = 0;
        beats_checked = 0;
        stall_left = 0;
        hold_stall_off = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_ties();
        hold_stall_off = 1'b1;
        test_overflow();
        hold_stall_off = 1'b0;
        test_random_sets();
        $display("Sent %0d records in %0d sets; checked %0d sorted index beats.",
                 records_sent, sets_sent, beats_checked);
        if (errors == 0 && sorted_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
